// File: rtl/vmu_pkg.sv
package vmu_pkg;

  // Default number format: Q16.16 in 32-bit words
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // Lanes and products per lane
  localparam int NUM_LANES = 4;
  localparam int NUM_PROD  = 4;

  // Operation codes carried in the kind field
  typedef enum logic [3:0] {
    KIND_ADD       = 4'd0,
    KIND_SUB       = 4'd1,
    KIND_SCALE     = 4'd2,
    KIND_DOT       = 4'd3,
    KIND_CROSS     = 4'd4,
    KIND_TRANSFORM = 4'd5,
    KIND_NORMALISE = 4'd6,
    KIND_LENGTH    = 4'd7,
    KIND_LOAD      = 4'd8
  } kind_t;

  // Input item
  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] aw;
    logic signed [31:0] bx;
    logic signed [31:0] by_comp;
    logic signed [31:0] bz;
    logic signed [31:0] factor;
    logic [1:0]         matrix_row;
    logic [1:0]         matrix_col;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] rw;
    logic signed [31:0] scalar;
    logic               overflow;
    logic               zero_length;
  } out_item_t;

  // Per-lane control: negate each product, and apply the fraction shift
  typedef struct packed {
    logic [NUM_PROD-1:0] neg;
    logic                shift;
  } lane_ctrl_t;

endpackage

// File: rtl/vmu_lane.sv
module vmu_lane #(
  parameter int WORD_BITS = vmu_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vmu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [WORD_BITS-1:0]   x [vmu_pkg::NUM_PROD],
  input  logic signed [WORD_BITS-1:0]   y [vmu_pkg::NUM_PROD],
  input  vmu_pkg::lane_ctrl_t           ctl,
  output logic signed [2*WORD_BITS+1:0] sum,
  output logic signed [WORD_BITS-1:0]   res,
  output logic                          ovf
);
  import vmu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int SW = 2 * W + 2;
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = -SW'(64'sd1 <<< (W - 1));

  logic signed [2*W-1:0] p_r [NUM_PROD];
  lane_ctrl_t            ctl_p_r;
  logic signed [SW-1:0]  sum_r;
  logic signed [SW-1:0]  sum_nxt;
  logic                  shift_s_r;
  logic signed [SW-1:0]  shifted;
  logic signed [W-1:0]   res_r;
  logic signed [W-1:0]   res_nxt;
  logic                  ovf_r;
  logic                  ovf_nxt;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_PROD; j++) begin
        p_r[j] <= x[j] * y[j];
      end
      ctl_p_r <= ctl;
    end
  end

  // Add the signed products at full precision
  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < NUM_PROD; j++) begin
      if (ctl_p_r.neg[j]) sum_nxt = sum_nxt - SW'(p_r[j]);
      else                sum_nxt = sum_nxt + SW'(p_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r     <= sum_nxt;
      shift_s_r <= ctl_p_r.shift;
    end
  end

  // When shift is set, drop the fraction bits (floor); then saturate to the word range
  always_comb begin
    shifted = shift_s_r ? (sum_r >>> FRAC_BITS) : sum_r;
    ovf_nxt = 1'b0;
    if (shifted > SMAX) begin
      res_nxt = W'(SMAX);
      ovf_nxt = 1'b1;
    end else if (shifted < SMIN) begin
      res_nxt = W'(SMIN);
      ovf_nxt = 1'b1;
    end else begin
      res_nxt = W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign sum = sum_r;
  assign res = res_r;
  assign ovf = ovf_r;

endmodule

// File: rtl/vmu_isqrt.sv
module vmu_isqrt #(
  parameter int WORD_BITS = vmu_pkg::WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*WORD_BITS-1:0] s_in,
  output logic [WORD_BITS-1:0]   root_out
);
  import vmu_pkg::*;

  localparam int W = WORD_BITS;

  logic [2*W-1:0] s_r    [W];
  logic [W:0]     rem_r  [W];
  logic [W-1:0]   root_r [W];

  // One root bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [2*W-1:0] s_i;
    logic [W:0]     rem_i;
    logic [W-1:0]   root_i;
    logic [W+2:0]   tmp;
    logic [W+2:0]   trial;

    if (k == 0) begin : g_first
      assign s_i    = s_in;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign s_i    = s_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    assign tmp   = {rem_i, s_i[2*W-1:2*W-2]};
    assign trial = {1'b0, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= {s_i[2*W-3:0], 2'b00};
        if (tmp >= trial) begin
          rem_r[k]  <= (W+1)'(tmp - trial);
          root_r[k] <= {root_i[W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= tmp[W:0];
          root_r[k] <= {root_i[W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_out = root_r[W-1];

endmodule

// File: rtl/vmu_div.sv
module vmu_div #(
  parameter int WORD_BITS = vmu_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vmu_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [WORD_BITS+FRAC_BITS-1:0] n_in,
  input  logic [WORD_BITS-1:0]           d_in,
  output logic [WORD_BITS+FRAC_BITS-1:0] q_out,
  output logic [WORD_BITS-1:0]           d_out
);
  import vmu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int NB = WORD_BITS + FRAC_BITS;

  logic [NB-1:0] n_r [NB];
  logic [W-1:0]  r_r [NB];
  logic [NB-1:0] q_r [NB];
  logic [W-1:0]  d_r [NB];

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [NB-1:0] n_i;
    logic [W-1:0]  r_i;
    logic [NB-1:0] q_i;
    logic [W-1:0]  d_i;
    logic [W:0]    tmp;

    if (k == 0) begin : g_first
      assign n_i = n_in;
      assign r_i = '0;
      assign q_i = '0;
      assign d_i = d_in;
    end else begin : g_next
      assign n_i = n_r[k-1];
      assign r_i = r_r[k-1];
      assign q_i = q_r[k-1];
      assign d_i = d_r[k-1];
    end

    assign tmp = {r_i, n_i[NB-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= {n_i[NB-2:0], 1'b0};
        d_r[k] <= d_i;
        if (tmp >= {1'b0, d_i}) begin
          r_r[k] <= W'(tmp - {1'b0, d_i});
          q_r[k] <= {q_i[NB-2:0], 1'b1};
        end else begin
          r_r[k] <= tmp[W-1:0];
          q_r[k] <= {q_i[NB-2:0], 1'b0};
        end
      end
    end
  end

  assign q_out = q_r[NB-1];
  assign d_out = d_r[NB-1];

endmodule

// File: rtl/vector_math_unit.sv
// Homogeneous 3D vector unit in signed fixed point (Q16.16 by default). It
// accepts one operation per cycle unless a finished result is blocked at the
// output, in order, and returns one result per operation except matrix loads
// and unused kinds, which give none. Four multiply lanes compute the products
// of add, subtract, scale, dot, cross and the 4x4 transform; normalise and
// length run through a pipelined square root (one root bit per stage) and
// three pipelined dividers (one quotient bit per stage). Every operation has
// the same latency from input transfer to result. A matrix load takes effect
// for every later operation. The matrix resets to identity.
module vector_math_unit #(
  parameter int FRAC_BITS = vmu_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = vmu_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vmu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vmu_pkg::out_item_t out_data
);
  import vmu_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int NB  = WORD_BITS + FRAC_BITS;
  localparam int SQ  = 3 + W;
  localparam int LAT = 3 + W + NB;

  localparam logic signed [W-1:0] WMAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN_V = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_Q  =
    (FRAC_BITS >= W - 1) ? WMAX_V : W'(64'd1 << FRAC_BITS);
  localparam logic [NB-1:0] QMAX_POS = NB'(WMAX_V);
  localparam logic [NB-1:0] QMAX_NEG = NB'(64'd1 << (W - 1));

  typedef struct packed {
    logic [3:0]          kind;
    logic signed [W-1:0] aw;
    logic [2:0]          neg;
    logic [2:0][W-1:0]   mag;
  } meta_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][W-1:0] r;
    logic [NUM_LANES-1:0]        ovf;
  } tail_t;

  function automatic logic signed [W-1:0] to_w(input logic [31:0] v);
    return W'(v);
  endfunction

  logic                  en;
  logic                  accept;
  logic signed [W-1:0]   mat_r [16];
  logic signed [W-1:0]   av [4];
  logic signed [W-1:0]   bv [3];
  logic signed [W-1:0]   fv;
  logic signed [W-1:0]   one_w;

  logic signed [W-1:0]   x_nxt [NUM_LANES][NUM_PROD];
  logic signed [W-1:0]   y_nxt [NUM_LANES][NUM_PROD];
  lane_ctrl_t            ctl_nxt [NUM_LANES];
  logic signed [W-1:0]   x_r [NUM_LANES][NUM_PROD];
  logic signed [W-1:0]   y_r [NUM_LANES][NUM_PROD];
  lane_ctrl_t            ctl_r [NUM_LANES];

  logic signed [2*W+1:0] lane_sum [NUM_LANES];
  logic signed [W-1:0]   lane_res [NUM_LANES];
  logic                  lane_ovf [NUM_LANES];

  meta_t                 meta_nxt;
  meta_t                 meta_r [1:LAT];
  tail_t                 tail_nxt;
  tail_t                 tail_r [5:LAT];
  logic                  v_r [1:LAT];

  logic [W-1:0]          root;
  logic [NB-1:0]         quo [3];
  logic [W-1:0]          dq [3];

  out_item_t             res_nxt;
  out_item_t             out_r;
  logic                  out_valid_r;

  // Advance unless a finished result is blocked behind a full output register
  assign en       = !(out_valid_r && !out_ready && v_r[LAT]);
  assign in_ready = en;
  assign accept   = in_valid && en;

  assign av[0] = to_w(in_data.ax);
  assign av[1] = to_w(in_data.ay);
  assign av[2] = to_w(in_data.az);
  assign av[3] = to_w(in_data.aw);
  assign bv[0] = to_w(in_data.bx);
  assign bv[1] = to_w(in_data.by_comp);
  assign bv[2] = to_w(in_data.bz);
  assign fv    = to_w(in_data.factor);
  assign one_w = W'(1);

  // Matrix store: identity after reset, written by load transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= (i % 5 == 0) ? ONE_Q : '0;
      end
    end else if (accept && kind_t'(in_data.kind) == KIND_LOAD) begin
      mat_r[{in_data.matrix_row, in_data.matrix_col}] <= fv;
    end
  end

  // Route operands to the lanes by operation
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      for (int j = 0; j < NUM_PROD; j++) begin
        x_nxt[i][j] = '0;
        y_nxt[i][j] = '0;
      end
      ctl_nxt[i] = '0;
    end
    unique case (kind_t'(in_data.kind))
      KIND_ADD, KIND_SUB: begin
        for (int i = 0; i < 3; i++) begin
          x_nxt[i][0]    = av[i];
          y_nxt[i][0]    = one_w;
          x_nxt[i][1]    = bv[i];
          y_nxt[i][1]    = one_w;
          ctl_nxt[i].neg = {2'b00, kind_t'(in_data.kind) == KIND_SUB, 1'b0};
        end
      end
      KIND_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          x_nxt[i][0]      = av[i];
          y_nxt[i][0]      = fv;
          ctl_nxt[i].shift = 1'b1;
        end
      end
      KIND_DOT: begin
        for (int j = 0; j < 3; j++) begin
          x_nxt[0][j] = av[j];
          y_nxt[0][j] = bv[j];
        end
        ctl_nxt[0].shift = 1'b1;
      end
      KIND_CROSS: begin
        x_nxt[0][0] = av[1]; y_nxt[0][0] = bv[2];
        x_nxt[0][1] = av[2]; y_nxt[0][1] = bv[1];
        x_nxt[1][0] = av[2]; y_nxt[1][0] = bv[0];
        x_nxt[1][1] = av[0]; y_nxt[1][1] = bv[2];
        x_nxt[2][0] = av[0]; y_nxt[2][0] = bv[1];
        x_nxt[2][1] = av[1]; y_nxt[2][1] = bv[0];
        for (int i = 0; i < 3; i++) begin
          ctl_nxt[i].neg   = 4'b0010;
          ctl_nxt[i].shift = 1'b1;
        end
      end
      KIND_TRANSFORM: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          for (int j = 0; j < NUM_PROD; j++) begin
            x_nxt[i][j] = av[j];
            y_nxt[i][j] = mat_r[j*4+i];
          end
          ctl_nxt[i].shift = 1'b1;
        end
      end
      KIND_NORMALISE, KIND_LENGTH: begin
        for (int j = 0; j < 3; j++) begin
          x_nxt[0][j] = av[j];
          y_nxt[0][j] = av[j];
        end
      end
      default: begin
      end
    endcase
  end

  // Side data that travels alongside the arithmetic
  always_comb begin
    meta_nxt.kind = in_data.kind;
    meta_nxt.aw   = av[3];
    for (int i = 0; i < 3; i++) begin
      meta_nxt.neg[i] = av[i][W-1];
      meta_nxt.mag[i] = av[i][W-1] ? W'(-av[i]) : W'(av[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      ctl_r     <= ctl_nxt;
      meta_r[1] <= meta_nxt;
      for (int k = 2; k <= LAT; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
      tail_r[5] <= tail_nxt;
      for (int k = 6; k <= LAT; k++) begin
        tail_r[k] <= tail_r[k-1];
      end
    end
  end

  // Occupancy of each stage; loads and unused kinds leave a bubble
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAT; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[1] <= accept && (in_data.kind <= 4'(KIND_LENGTH));
      for (int k = 2; k <= LAT; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    vmu_lane #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .x   (x_r[i]),
      .y   (y_r[i]),
      .ctl (ctl_r[i]),
      .sum (lane_sum[i]),
      .res (lane_res[i]),
      .ovf (lane_ovf[i])
    );
    assign tail_nxt.r[i]   = lane_res[i];
    assign tail_nxt.ovf[i] = lane_ovf[i];
  end

  vmu_isqrt #(
    .WORD_BITS(WORD_BITS)
  ) u_isqrt (
    .clk      (clk),
    .en       (en),
    .s_in     (lane_sum[0][2*W-1:0]),
    .root_out (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    vmu_div #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .n_in  ({meta_r[SQ].mag[i], {FRAC_BITS{1'b0}}}),
      .d_in  (root),
      .q_out (quo[i]),
      .d_out (dq[i])
    );
  end

  // Merge lane, root and quotient results into one result item
  always_comb begin
    logic signed [W-1:0] rv [4];
    logic signed [W-1:0] sc;
    logic                ovf;
    logic                zl;
    for (int i = 0; i < 4; i++) begin
      rv[i] = '0;
    end
    sc  = '0;
    ovf = 1'b0;
    zl  = 1'b0;
    unique case (kind_t'(meta_r[LAT].kind))
      KIND_ADD, KIND_SUB, KIND_SCALE, KIND_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          rv[i] = $signed(tail_r[LAT].r[i]);
        end
        rv[3] = ONE_Q;
        ovf   = |tail_r[LAT].ovf;
      end
      KIND_DOT: begin
        sc  = $signed(tail_r[LAT].r[0]);
        ovf = tail_r[LAT].ovf[0];
      end
      KIND_TRANSFORM: begin
        for (int i = 0; i < 4; i++) begin
          rv[i] = $signed(tail_r[LAT].r[i]);
        end
        ovf = |tail_r[LAT].ovf;
      end
      KIND_LENGTH: begin
        ovf = dq[0][W-1];
        sc  = dq[0][W-1] ? WMAX_V : $signed(dq[0]);
      end
      KIND_NORMALISE: begin
        rv[3] = meta_r[LAT].aw;
        if (dq[0] == '0) begin
          zl = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (!meta_r[LAT].neg[i]) begin
              if (quo[i] > QMAX_POS) begin
                rv[i] = WMAX_V;
                ovf   = 1'b1;
              end else begin
                rv[i] = $signed(W'(quo[i]));
              end
            end else begin
              if (quo[i] > QMAX_NEG) begin
                rv[i] = WMIN_V;
                ovf   = 1'b1;
              end else begin
                rv[i] = -$signed(W'(quo[i]));
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    res_nxt.rx          = 32'(rv[0]);
    res_nxt.ry          = 32'(rv[1]);
    res_nxt.rz          = 32'(rv[2]);
    res_nxt.rw          = 32'(rv[3]);
    res_nxt.scalar      = 32'(sc);
    res_nxt.overflow    = ovf;
    res_nxt.zero_length = zl;
  end

  // Output register: load a finished result, drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && v_r[LAT]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_r[LAT]) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/vmu_checker.sv
module vmu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input vmu_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input vmu_pkg::out_item_t out_data
);
  import vmu_pkg::*;

  // Hold an offered transfer until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transfer withdrawn or changed while stalled");

  // Hold a result until it is transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // A zero vector normalises to zero with no saturation
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_length |->
      out_data.rx == 0 && out_data.ry == 0 && out_data.rz == 0 &&
      out_data.scalar == 0 && !out_data.overflow)
    else $error("zero-length result carries data");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind vector_math_unit vmu_checker u_vmu_checker (.*);

// File: verif/vector_math_unit_tb.sv
module vector_math_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vmu_pkg::*;

  localparam logic [3:0] KIND_SPARE_LO = 4'd9;
  localparam logic [3:0] KIND_SPARE_HI = 4'd15;
  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] W_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] W_MIN  = 32'sh8000_0000;
  localparam int N_RANDOM   = 650;
  localparam int DRAIN_WAIT = 200;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // sideband that travels with the presented item
  bit        cur_typed = 1'b0;
  out_item_t cur_want = '0;
  logic      in_took = 1'b0;

  logic signed [31:0] vmu_matrix [16];
  out_item_t          pending_results [$];
  stim_row_t          stim_table [$];
  int                 fail_count = 0;
  int                 result_count = 0;
  int                 sent_count = 0;
  bit                 stim_done = 1'b0;

  vector_math_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t vec_item(logic [3:0] k,
      logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
      logic signed [31:0] aw, logic signed [31:0] bx, logic signed [31:0] by,
      logic signed [31:0] bz, logic signed [31:0] f, int row, int col);
    in_item_t it;
    it.kind = k; it.ax = ax; it.ay = ay; it.az = az; it.aw = aw;
    it.bx = bx; it.by_comp = by; it.bz = bz; it.factor = f;
    it.matrix_row = 2'(row); it.matrix_col = 2'(col);
    return it;
  endfunction

  function automatic out_item_t res_item(logic signed [31:0] rx,
      logic signed [31:0] ry, logic signed [31:0] rz, logic signed [31:0] rw,
      logic signed [31:0] sc, logic ov, logic zl);
    out_item_t o;
    o.rx = rx; o.ry = ry; o.rz = rz; o.rw = rw; o.scalar = sc;
    o.overflow = ov; o.zero_length = zl;
    return o;
  endfunction

  // clamp a wide value to the word range
  function automatic logic signed [31:0] clamp_word(wide_t v, ref bit hit);
    if (v > wide_t'(W_MAX)) begin
      hit = 1'b1;
      return W_MAX;
    end
    if (v < wide_t'(W_MIN)) begin
      hit = 1'b1;
      return W_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [127:0] root_floor(logic [127:0] s);
    logic [127:0] c;
    logic [127:0] t;
    c = '0;
    for (int b = 62; b >= 0; b--) begin
      t = c | (128'd1 << b);
      if (t * t <= s) c = t;
    end
    return c;
  endfunction

  // compute the result of one operation; loads update the matrix copy
  function automatic bit vmu_predict(in_item_t it, ref out_item_t o);
    wide_t a [4];
    wide_t b [3];
    wide_t f, acc, sq;
    logic [127:0] q, nm, qq;
    bit hit;
    bit zl;
    logic signed [31:0] r [4];
    logic signed [31:0] sc;
    if (it.kind == KIND_LOAD) begin
      vmu_matrix[{it.matrix_row, it.matrix_col}] = it.factor;
      return 1'b0;
    end
    if (it.kind > KIND_LOAD) return 1'b0;
    a[0] = wide_t'(it.ax); a[1] = wide_t'(it.ay); a[2] = wide_t'(it.az);
    a[3] = wide_t'(it.aw);
    b[0] = wide_t'(it.bx); b[1] = wide_t'(it.by_comp); b[2] = wide_t'(it.bz);
    f = wide_t'(it.factor);
    hit = 1'b0; zl = 1'b0; sc = '0;
    for (int i = 0; i < 4; i++) r[i] = '0;
    case (kind_t'(it.kind))
      KIND_ADD, KIND_SUB: begin
        for (int i = 0; i < 3; i++)
          r[i] = clamp_word(it.kind == KIND_ADD ? a[i] + b[i] : a[i] - b[i], hit);
        r[3] = Q_ONE;
      end
      KIND_SCALE: begin
        for (int i = 0; i < 3; i++) r[i] = clamp_word((a[i] * f) >>> 16, hit);
        r[3] = Q_ONE;
      end
      KIND_DOT: sc = clamp_word((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16, hit);
      KIND_CROSS: begin
        r[0] = clamp_word((a[1] * b[2] - a[2] * b[1]) >>> 16, hit);
        r[1] = clamp_word((a[2] * b[0] - a[0] * b[2]) >>> 16, hit);
        r[2] = clamp_word((a[0] * b[1] - a[1] * b[0]) >>> 16, hit);
        r[3] = Q_ONE;
      end
      KIND_TRANSFORM: begin
        for (int i = 0; i < 4; i++) begin
          acc = '0;
          for (int j = 0; j < 4; j++) acc += a[j] * wide_t'(vmu_matrix[j * 4 + i]);
          r[i] = clamp_word(acc >>> 16, hit);
        end
      end
      default: begin
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        q = root_floor(sq);
        if (it.kind == KIND_LENGTH) begin
          sc = clamp_word(wide_t'(q), hit);
        end else if (q == 0) begin
          zl = 1'b1;
          r[3] = it.aw;
        end else begin
          for (int i = 0; i < 3; i++) begin
            nm = (a[i] < 0 ? -a[i] : a[i]) << 16;
            qq = nm / q;
            r[i] = clamp_word(a[i] < 0 ? -wide_t'(qq) : wide_t'(qq), hit);
          end
          r[3] = it.aw;
        end
      end
    endcase
    o = res_item(r[0], r[1], r[2], r[3], sc, hit, zl);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string fld, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, fld, got, want);
    fail_count++;
  endtask

  // random word: mostly small Q16.16 values, some full range, some extremes
  function automatic logic signed [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 5))
          0: return W_MIN;
          1: return W_MAX;
          2: return '0;
          3: return -32'sd1;
          4: return 32'sd1;
          default: return Q_ONE;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic in_item_t pick_item();
    logic [3:0] k;
    if ($urandom_range(0, 99) < 4) k = 4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    else k = 4'($urandom_range(KIND_ADD, KIND_LOAD));
    return vec_item(k, pick_word(), pick_word(), pick_word(), pick_word(),
                    pick_word(), pick_word(), pick_word(), pick_word(),
                    $urandom_range(0, 3), $urandom_range(0, 3));
  endfunction

  task automatic add_row(in_item_t it, bit typed, out_item_t want);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    stim_table.push_back(row);
  endtask

  // directed table: typed expectations only where obvious
  initial begin
    add_row(vec_item(KIND_ADD, Q_ONE, -Q_ONE, 0, 0, 2 * Q_ONE, 32'sh8000, 0, 0, 0, 0),
            1, res_item(3 * Q_ONE, 32'shffff_8000, 0, Q_ONE, 0, 0, 0));
    add_row(vec_item(KIND_ADD, W_MAX, 0, 0, 0, W_MAX, 0, 0, 0, 0, 0),
            1, res_item(W_MAX, 0, 0, Q_ONE, 0, 1, 0));
    add_row(vec_item(KIND_SUB, W_MIN, 0, 0, 0, 1, 0, 0, 0, 0, 0),
            1, res_item(W_MIN, 0, 0, Q_ONE, 0, 1, 0));
    add_row(vec_item(KIND_TRANSFORM, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, 0, 0, 0),
            1, res_item(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, 0, 0, 0));
    add_row(vec_item(KIND_NORMALISE, 0, 0, 0, 32'sh0001_2345, 0, 0, 0, 0, 0, 0),
            1, res_item(0, 0, 0, 32'sh0001_2345, 0, 0, 1));
    add_row(vec_item(KIND_LENGTH, 3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0),
            1, res_item(0, 0, 0, 0, 5 * Q_ONE, 0, 0));
    add_row(vec_item(KIND_SCALE, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0, W_MIN, 0, 0),
            1, res_item(W_MAX, W_MAX, W_MAX, Q_ONE, 0, 1, 0));
    add_row(vec_item(KIND_LENGTH, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_DOT, W_MAX, W_MIN, Q_ONE, 0, W_MAX, W_MAX, -Q_ONE, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_DOT, W_MAX, W_MAX, W_MAX, 0, W_MAX, W_MAX, W_MAX, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_CROSS, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_CROSS, W_MIN, W_MAX, W_MIN, 0, W_MAX, W_MIN, W_MAX, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_NORMALISE, 3 * Q_ONE, -4 * Q_ONE, 0, Q_ONE, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_NORMALISE, W_MIN, W_MIN, W_MIN, W_MAX, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_NORMALISE, 1, 0, 0, W_MIN, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_SPARE_LO, W_MAX, 0, 0, 0, 0, 0, 0, 0, 3, 3), 0, '0);
    add_row(vec_item(KIND_SPARE_HI, W_MIN, 0, 0, 0, 0, 0, 0, W_MAX, 3, 3), 0, '0);
    add_row(vec_item(KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 2 * Q_ONE, 3, 3), 0, '0);
    add_row(vec_item(KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, W_MIN, 0, 3), 0, '0);
    add_row(vec_item(KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, W_MAX, 2, 1), 0, '0);
    add_row(vec_item(KIND_TRANSFORM, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_TRANSFORM, W_MAX, W_MIN, W_MAX, W_MIN, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_SCALE, Q_ONE, -Q_ONE, W_MAX, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(vec_item(KIND_SUB, W_MAX, W_MIN, 0, 0, W_MIN, W_MAX, 0, 0, 0, 0), 0, '0);
  end

  // source: bursts of transfers with random gaps between them
  initial begin
    int gap;
    int burst;
    int total;
    stim_row_t row;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    total = stim_table.size() + N_RANDOM;
    burst = 0;
    for (int n = 0; n < total; n++) begin
      if (n < stim_table.size()) begin
        row = stim_table[n];
      end else begin
        row.item = pick_item();
        row.typed = 1'b0;
        row.want = '0;
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst--;
      in_valid  <= 1'b1;
      in_data   <= row.item;
      cur_typed <= row.typed;
      cur_want  <= row.want;
      @(negedge clk);
      while (!in_took) @(negedge clk);
      sent_count++;
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // sink: ready pattern switching between open, sparse and long stalls
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ((left % 16) < 4);
      endcase
    end
  end

  // input transfers: predict and queue the expected result
  always @(posedge clk) begin
    out_item_t o;
    in_took <= in_valid && in_ready;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) vmu_matrix[i] <= (i % 5 == 0) ? Q_ONE : '0;
    end else if (in_valid && in_ready) begin
      if (vmu_predict(in_data, o)) pending_results.push_back(cur_typed ? cur_want : o);
    end
  end

  // result transfers: compare against the oldest expectation
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result rx", out_data.rx, 32'h0);
      end else begin
        w = pending_results.pop_front();
        if (out_data.rx !== w.rx) report_mismatch("rx", out_data.rx, w.rx);
        if (out_data.ry !== w.ry) report_mismatch("ry", out_data.ry, w.ry);
        if (out_data.rz !== w.rz) report_mismatch("rz", out_data.rz, w.rz);
        if (out_data.rw !== w.rw) report_mismatch("rw", out_data.rw, w.rw);
        if (out_data.scalar !== w.scalar)
          report_mismatch("scalar", out_data.scalar, w.scalar);
        if (out_data.overflow !== w.overflow)
          report_mismatch("overflow", 32'(out_data.overflow), 32'(w.overflow));
        if (out_data.zero_length !== w.zero_length)
          report_mismatch("zero_length", 32'(out_data.zero_length), 32'(w.zero_length));
      end
    end
  end

  // drain, settle, report
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d input transfers (%0d directed) and checked %0d results",
             sent_count, stim_table.size(), result_count);
    if (fail_count == 0) begin
      $display("vector_math_unit_tb: PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("vector_math_unit_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("vector_math_unit_tb: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/vmu_pkg.sv
rtl/vmu_lane.sv
rtl/vmu_isqrt.sv
rtl/vmu_div.sv
rtl/vector_math_unit.sv
rtl/vmu_checker.sv
verif/vector_math_unit_tb.sv
